>>> rtl/core/assert_macros.svh
// Assertion macros shared by the motor speed PID core.
// Clocked implication checks; they compile to nothing when ASSERT_OFF is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/mspt_pkg.sv
// Types, constants and the microprogram of the motor speed PID core.
// No dependencies; imported by every core file but mspt_in_if and the macros.
package mspt_pkg;

  localparam int unsigned CFG_W    = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned VEL_W    = 32;
  localparam int unsigned DUTY_W   = 23;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned HIGH_W   = 24;
  localparam int unsigned MUL_W    = 32;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned TERM_W   = 48;
  localparam int unsigned ACC_W    = 50;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned UCODE_DEPTH = 2 ** STEP_W;
  localparam int unsigned Q_FRAC   = 16;
  localparam int unsigned HIGH_LSB = 37;

  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_TARGET   = 3'd1,
    REG_PERIOD   = 3'd2,
    REG_GAIN_P   = 3'd3,
    REG_GAIN_I   = 3'd4,
    REG_GAIN_D   = 3'd5
  } reg_idx_t;

  // 0.279018 in Q32, and floor(x / 100) == (x * RECIP_100) >> 37 for 32-bit x.
  localparam logic [MUL_W-1:0] VEL_K     = 32'd1198373185;
  localparam logic [MUL_W-1:0] THOUSAND  = 32'd1000;
  localparam logic [MUL_W-1:0] RECIP_100 = 32'd1374389535;

  localparam logic [PROD_W-1:0] PROD_LIMIT = 64'h4000_0000_0000_0000;
  localparam logic [PROD_W-1:0] ROUND_HALF = 64'd32768;

  localparam logic [TERM_W-1:0] VQ_POS_MAX = 48'h0000_7FFF_FFFF;
  localparam logic [TERM_W-1:0] VQ_NEG_MAX = 48'h0000_8000_0000;
  localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh8000_0000;

  localparam logic signed [VEL_W:0] INTEG_LIMIT = 33'sd6553600;
  localparam logic signed [ACC_W-1:0] ACC_HUNDRED = 50'sd6553600;
  localparam logic signed [ACC_W-1:0] ACC_ONE = 50'sd65536;
  localparam logic [DUTY_W-1:0] DUTY_HUNDRED = 23'd6553600;
  localparam logic [DUTY_W-1:0] DUTY_MILLI = 23'd66;

  localparam logic signed [PROD_W+1:0] DIST_BIAS = 66'sd32768000;
  localparam logic [PHASE_W-1:0] PID_PHASE = 4'd9;
  localparam logic [PHASE_W-1:0] PHASE_RESTART = 4'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd1000000;
  localparam logic [CFG_W-1:0] GAIN_P_RESET = 32'd12054;
  localparam logic [CFG_W-1:0] GAIN_I_RESET = 32'd4405;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_VEL,
    OP_DISTP,
    OP_FINCMP,
    OP_ERR,
    OP_DERIV,
    OP_TERM,
    OP_TERM_ACC,
    OP_TERM_ADD,
    OP_ACC_ADD,
    OP_CLAMP,
    OP_HIGH,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    MA_DIFF,
    MA_COUNT,
    MA_TARGET,
    MA_ERR,
    MA_DERIV,
    MA_INTEG,
    MA_DUTY,
    MA_PROD_HI
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_VEL_K,
    MB_THOUSAND,
    MB_GAIN_P,
    MB_GAIN_D,
    MB_GAIN_I,
    MB_PERIOD,
    MB_RECIP
  } mul_b_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_HOLD_IN,
    JC_IF_FIN,
    JC_IF_NO_PID,
    JC_HOLD_OUT
  } jump_t;

  typedef struct packed {
    op_t               op;
    mul_a_t            mul_a;
    mul_b_t            mul_b;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic finished;
    logic pid_due;
    logic out_busy;
  } status_t;

  localparam logic [STEP_W-1:0] STEP_LOAD = 4'd0;
  localparam logic [STEP_W-1:0] STEP_HIGH = 4'd12;
  localparam logic [STEP_W-1:0] STEP_OUT  = 4'd15;

  // The multiplier registers its product, so each step consumes what the step
  // before it launched.
  localparam ctl_word_t UCODE [UCODE_DEPTH] = '{
    '{OP_LOAD,     MA_DIFF,    MB_VEL_K,    JC_HOLD_IN,   STEP_LOAD},
    '{OP_NOP,      MA_DIFF,    MB_VEL_K,    JC_IF_FIN,    STEP_OUT},
    '{OP_VEL,      MA_COUNT,   MB_VEL_K,    JC_NEXT,      STEP_LOAD},
    '{OP_DISTP,    MA_TARGET,  MB_THOUSAND, JC_NEXT,      STEP_LOAD},
    '{OP_FINCMP,   MA_DIFF,    MB_VEL_K,    JC_IF_NO_PID, STEP_HIGH},
    '{OP_ERR,      MA_DIFF,    MB_VEL_K,    JC_NEXT,      STEP_LOAD},
    '{OP_DERIV,    MA_ERR,     MB_GAIN_P,   JC_NEXT,      STEP_LOAD},
    '{OP_TERM,     MA_DERIV,   MB_GAIN_D,   JC_NEXT,      STEP_LOAD},
    '{OP_TERM_ACC, MA_INTEG,   MB_GAIN_I,   JC_NEXT,      STEP_LOAD},
    '{OP_TERM_ADD, MA_DIFF,    MB_VEL_K,    JC_NEXT,      STEP_LOAD},
    '{OP_ACC_ADD,  MA_DIFF,    MB_VEL_K,    JC_NEXT,      STEP_LOAD},
    '{OP_CLAMP,    MA_DIFF,    MB_VEL_K,    JC_NEXT,      STEP_LOAD},
    '{OP_NOP,      MA_DUTY,    MB_PERIOD,   JC_NEXT,      STEP_LOAD},
    '{OP_NOP,      MA_PROD_HI, MB_RECIP,    JC_NEXT,      STEP_LOAD},
    '{OP_HIGH,     MA_DIFF,    MB_VEL_K,    JC_NEXT,      STEP_LOAD},
    '{OP_OUT,      MA_DIFF,    MB_VEL_K,    JC_HOLD_OUT,  STEP_LOAD}
  };

endpackage

>>> rtl/core/mspt_in_if.sv
// Input channel of the motor speed PID core: one encoder count per word.
// Depends on nothing; the width follows COUNT_BITS.
interface mspt_in_if #(parameter int unsigned COUNT_BITS = 24) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] pulse_count;

  modport source (output valid, output pulse_count, input ready);
  modport sink (input valid, input pulse_count, output ready);
endinterface

>>> rtl/core/mspt_out_if.sv
// Result channel of the motor speed PID core: one result word per tick.
// Field widths come from mspt_pkg.
interface mspt_out_if import mspt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VEL_W-1:0]  velocity;
  logic [DUTY_W-1:0]        duty_percent;
  logic [HIGH_W-1:0]        high_time_ns;
  logic                     pid_updated;
  logic                     done_res;

  modport source (output valid, output velocity, output duty_percent, output high_time_ns,
                  output pid_updated, output done_res, input ready);
  modport sink (input valid, input velocity, input duty_percent, input high_time_ns,
                input pid_updated, input done_res, output ready);
endinterface

>>> rtl/core/motor_speed_pid_tick.sv
// Speed PID tick for one motor axis, Q16.16 throughout. Each word on sample
// carries the running encoder count; each produces exactly one word on result
// with the window velocity, the duty, the PWM high time and the flags. All
// products go one at a time through a single registered 32x32 multiplier
// under a 16-step microprogram that skips the PID steps when no update is due
// and jumps from step 1 to the output step once done; the output step holds
// while the last result waits on result.ready. The next word is taken while
// a finished result still waits. The user must write configuration through
// cfg_we, cfg_index, cfg_data only while no tick is in flight; not enforced.
module motor_speed_pid_tick import mspt_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 10,
  parameter int unsigned COUNT_BITS   = 24
) (
  input  logic             clk,
  input  logic             rst,
  mspt_in_if.sink          sample,
  mspt_out_if.source       result,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  ctl_word_t ctl;
  status_t   status;

  mspt_useq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .status   (status),
    .ctl      (ctl),
    .in_ready (sample.ready)
  );

  mspt_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pulse_count  (sample.pulse_count),
    .out_ready    (result.ready),
    .status       (status),
    .out_valid    (result.valid),
    .out_velocity (result.velocity),
    .out_duty     (result.duty_percent),
    .out_high     (result.high_time_ns),
    .out_updated  (result.pid_updated),
    .out_done     (result.done_res)
  );

endmodule

>>> rtl/core/mspt_useq.sv
// Microcode sequencer: step counter, control store readout and jump logic.
// Uses the microprogram and types of mspt_pkg.
module mspt_useq import mspt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  status_t   status,
  output ctl_word_t ctl,
  output logic      in_ready
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctl_word_t         word;
  logic              hold;

  assign word     = UCODE[step];
  assign in_ready = (word.jump == JC_HOLD_IN);

  always_comb begin
    hold      = 1'b0;
    step_next = step + 1'b1;
    unique case (word.jump)
      JC_NEXT: begin
      end
      JC_HOLD_IN: begin
        hold = !in_valid;
      end
      JC_IF_FIN: begin
        if (status.finished) step_next = word.target;
      end
      JC_IF_NO_PID: begin
        if (!status.pid_due) step_next = word.target;
      end
      JC_HOLD_OUT: begin
        hold      = status.out_busy;
        step_next = word.target;
      end
      default: begin
      end
    endcase
    if (hold) step_next = step;
    // A waiting step must not fire its datapath operation.
    ctl = word;
    if (hold) ctl.op = OP_NOP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/core/mspt_datapath.sv
// Datapath of the motor speed PID core: registers, window, shared multiplier
// and result register, driven by control words from mspt_useq. Uses mspt_pkg.
`include "assert_macros.svh"
module mspt_datapath import mspt_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 10,
  parameter int unsigned COUNT_BITS   = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_word_t               ctl,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic [COUNT_BITS-1:0]   pulse_count,
  input  logic                    out_ready,
  output status_t                 status,
  output logic                    out_valid,
  output logic signed [VEL_W-1:0] out_velocity,
  output logic [DUTY_W-1:0]       out_duty,
  output logic [HIGH_W-1:0]       out_high,
  output logic                    out_updated,
  output logic                    out_done
);

  // Configuration registers.
  logic signed [VEL_W-1:0] setpoint;
  logic [CFG_W-1:0]        target;
  logic [PERIOD_W-1:0]     period;
  logic [CFG_W-1:0]        gain_p;
  logic [CFG_W-1:0]        gain_i;
  logic [CFG_W-1:0]        gain_d;

  // Controller state.
  logic [COUNT_BITS-1:0]   win [WINDOW_DEPTH];
  logic [PHASE_W-1:0]      phase;
  logic signed [VEL_W-1:0] prev_err;
  logic signed [VEL_W-1:0] integral;
  logic [DUTY_W-1:0]       duty;
  logic                    finished;

  // Working registers of one tick.
  logic                    fin_pend;
  logic                    updated;
  logic signed [VEL_W-1:0] vel;
  logic [HIGH_W-1:0]       high;
  logic [PROD_W-1:0]       prod;
  logic                    msign;
  logic [PROD_W-1:0]       distp;
  logic signed [VEL_W-1:0] err;
  logic signed [VEL_W-1:0] integ;
  logic signed [VEL_W:0]   deriv;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0] acc;

  // Combinational values.
  logic [COUNT_BITS:0]     diff;
  logic                    diff_neg;
  logic [COUNT_BITS-1:0]   diff_mag;
  logic [MUL_W-1:0]        err_mag;
  logic [MUL_W-1:0]        deriv_mag;
  logic [MUL_W-1:0]        integ_mag;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic                    mul_a_neg;
  logic [PROD_W-1:0]       vsum;
  logic [TERM_W-1:0]       vq;
  logic signed [VEL_W-1:0] vel_new;
  logic signed [VEL_W:0]   sp_diff;
  logic signed [VEL_W-1:0] err_new;
  logic signed [VEL_W:0]   integ_sum;
  logic signed [VEL_W-1:0] integ_new;
  logic [PROD_W-1:0]       p_sat;
  logic [PROD_W-1:0]       psum;
  logic signed [TERM_W-1:0] term_pos;
  logic signed [TERM_W-1:0] term_new;
  logic [DUTY_W-1:0]       duty_new;
  logic signed [PROD_W+1:0] dist_lhs;
  logic signed [PROD_W+1:0] thr_shift;
  logic signed [PROD_W+1:0] dist_rhs;
  logic                    fin_cmp;
  logic                    pid_due;

  assign diff     = {1'b0, win[0]} - {1'b0, win[WINDOW_DEPTH-1]};
  assign diff_neg = diff[COUNT_BITS];
  assign diff_mag = diff_neg ? (~diff[COUNT_BITS-1:0] + 1'b1) : diff[COUNT_BITS-1:0];

  assign err_mag   = err[VEL_W-1] ? (~err + 32'd1) : err;
  assign deriv_mag = deriv[VEL_W] ? (~deriv[MUL_W-1:0] + 32'd1) : deriv[MUL_W-1:0];
  assign integ_mag = integ[VEL_W-1] ? (~integ + 32'd1) : integ;

  always_comb begin
    mul_a     = '0;
    mul_a_neg = 1'b0;
    unique case (ctl.mul_a)
      MA_DIFF: begin
        mul_a     = MUL_W'(diff_mag);
        mul_a_neg = diff_neg;
      end
      MA_COUNT:   mul_a = MUL_W'(win[0]);
      MA_TARGET:  mul_a = target;
      MA_ERR: begin
        mul_a     = err_mag;
        mul_a_neg = err[VEL_W-1];
      end
      MA_DERIV: begin
        mul_a     = deriv_mag;
        mul_a_neg = deriv[VEL_W];
      end
      MA_INTEG: begin
        mul_a     = integ_mag;
        mul_a_neg = integ[VEL_W-1];
      end
      MA_DUTY:    mul_a = MUL_W'(duty);
      MA_PROD_HI: mul_a = prod[Q_FRAC +: MUL_W];
      default:    mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.mul_b)
      MB_VEL_K:    mul_b = VEL_K;
      MB_THOUSAND: mul_b = THOUSAND;
      MB_GAIN_P:   mul_b = gain_p;
      MB_GAIN_D:   mul_b = gain_d;
      MB_GAIN_I:   mul_b = gain_i;
      MB_PERIOD:   mul_b = MUL_W'(period);
      MB_RECIP:    mul_b = RECIP_100;
      default:     mul_b = '0;
    endcase
  end

  // Velocity: round half away from zero to Q16.16, then saturate.
  always_comb begin
    vsum = prod + ROUND_HALF;
    vq   = vsum[Q_FRAC +: TERM_W];
    if (msign) begin
      vel_new = (vq > VQ_NEG_MAX) ? VEL_MIN : (~vq[VEL_W-1:0] + 32'd1);
    end else begin
      vel_new = (vq > VQ_POS_MAX) ? VEL_MAX : vq[VEL_W-1:0];
    end
  end

  always_comb begin
    sp_diff = {setpoint[VEL_W-1], setpoint} - {vel[VEL_W-1], vel};
    if (sp_diff[VEL_W] != sp_diff[VEL_W-1]) begin
      err_new = sp_diff[VEL_W] ? VEL_MIN : VEL_MAX;
    end else begin
      err_new = sp_diff[VEL_W-1:0];
    end
    integ_sum = {integral[VEL_W-1], integral} + {prev_err[VEL_W-1], prev_err};
    if (integ_sum > INTEG_LIMIT || integ_sum < -INTEG_LIMIT) begin
      integ_new = '0;
    end else begin
      integ_new = integ_sum[VEL_W-1:0];
    end
  end

  // Gain product: saturate the magnitude, round back to Q16.16, apply sign.
  always_comb begin
    p_sat    = (prod > PROD_LIMIT) ? PROD_LIMIT : prod;
    psum     = p_sat + ROUND_HALF;
    term_pos = {1'b0, psum[Q_FRAC +: TERM_W-1]};
    term_new = msign ? -term_pos : term_pos;
  end

  always_comb begin
    if (acc > ACC_HUNDRED) begin
      duty_new = DUTY_HUNDRED;
    end else if (acc < ACC_ONE) begin
      duty_new = DUTY_MILLI;
    end else begin
      duty_new = acc[DUTY_W-1:0];
    end
  end

  // Distance check without a divide: the rounded count * K / 1000 reaches the
  // target exactly when count * K >= (target * 1000 << 16) - 1000 * 32768.
  assign dist_lhs  = {2'b00, distp};
  assign thr_shift = {2'b00, prod[TERM_W-1:0], 16'h0000};
  assign dist_rhs  = thr_shift - DIST_BIAS;
  assign fin_cmp   = (dist_lhs >= dist_rhs);
  assign pid_due   = (phase > PID_PHASE);

  assign status.finished = finished;
  assign status.pid_due  = pid_due;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
      target   <= '0;
      period   <= PERIOD_RESET;
      gain_p   <= GAIN_P_RESET;
      gain_i   <= GAIN_I_RESET;
      gain_d   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT: setpoint <= cfg_data;
        REG_TARGET:   target   <= cfg_data;
        REG_PERIOD:   period   <= cfg_data[PERIOD_W-1:0];
        REG_GAIN_P:   gain_p   <= cfg_data;
        REG_GAIN_I:   gain_i   <= cfg_data;
        REG_GAIN_D:   gain_d   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) win[i] <= '0;
    end else if (ctl.op == OP_LOAD && !finished) begin
      win[0] <= pulse_count;
      for (int i = 1; i < WINDOW_DEPTH; i++) win[i] <= win[i-1];
    end
  end

  // The multiplier runs every cycle; only the step after a launch reads it.
  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    msign <= mul_a_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      prev_err <= '0;
      integral <= '0;
      duty     <= '0;
      finished <= 1'b0;
      updated  <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_LOAD:  updated <= 1'b0;
        OP_FINCMP: begin
          phase <= pid_due ? PHASE_RESTART : (phase + 1'b1);
        end
        OP_CLAMP: begin
          duty     <= duty_new;
          prev_err <= err;
          integral <= integ;
          updated  <= 1'b1;
        end
        OP_HIGH:  finished <= fin_pend;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_VEL:      vel   <= vel_new;
      OP_DISTP:    distp <= prod;
      OP_FINCMP:   fin_pend <= fin_cmp;
      OP_ERR: begin
        err   <= err_new;
        integ <= integ_new;
      end
      OP_DERIV:    deriv <= {err[VEL_W-1], err} - {prev_err[VEL_W-1], prev_err};
      OP_TERM:     term  <= term_new;
      OP_TERM_ACC: begin
        acc  <= ACC_W'(term);
        term <= term_new;
      end
      OP_TERM_ADD: begin
        acc  <= acc + ACC_W'(term);
        term <= term_new;
      end
      OP_ACC_ADD:  acc   <= acc + ACC_W'(term);
      OP_HIGH:     high  <= fin_pend ? '0 : prod[HIGH_LSB +: HIGH_W];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_OUT) begin
      out_velocity <= vel;
      out_duty     <= duty;
      out_high     <= high;
      out_updated  <= updated;
      out_done     <= finished;
    end
  end

  `ASSERT_NEXT(a_done_latched, clk, rst, finished, finished, "done latch dropped")
  `ASSERT_NEXT(a_duty_frozen, clk, rst, finished, $stable(duty) && $stable(integral), "state moved after done")
  `ASSERT_IMPL(a_no_pid_after_done, clk, rst, ctl.op == OP_CLAMP, !finished, "PID step after done")
  `ASSERT_IMPL(a_done_no_high, clk, rst, out_valid && out_done, out_high == '0, "high time with done")

endmodule
